// ----- rtl/matrix_shell_rotate_defines.svh -----
// ============================================================================
// Assertion macros for the matrix shell rotation block
// Clocked concurrent assertion helpers used by the port-level checker.
// ============================================================================
`ifndef MATRIX_SHELL_ROTATE_DEFINES_SVH
`define MATRIX_SHELL_ROTATE_DEFINES_SVH

// Property checked at every rising edge of clk, switched off while in reset.
`define MSR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge of clk.
`define MSR_ASSERT_NEVER(label, cond, msg) \
    `MSR_ASSERT_CLK(label, !(cond), msg)

`endif

// ----- rtl/msr_pkg.sv -----
// ============================================================================
// msr_pkg
// Shared constants, transaction types and geometry types of the block.
// ============================================================================
`default_nettype none

package msr_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int CNT_W     = $clog2(4 * MAX_DIM - 4 + 1);
    localparam int P_W       = CNT_W + 1;
    localparam int AMT_W     = 16;
    localparam int SHELL_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = AMT_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT     = 2'd0,
        REG_COL_COUNT     = 2'd1,
        REG_SHELL_NUMBER  = 2'd2,
        REG_ROTATE_AMOUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                     opcode;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] element_value;
    } msr_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     on_ring;
    } msr_out_t;

    // Ring geometry derived from the configuration registers.
    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] k;
        logic [DIM_W-1:0] hr;
        logic [DIM_W-1:0] hc;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] m;
        logic [CNT_W-1:0] cnt;
    } geom_t;

endpackage

`default_nettype wire

// ----- rtl/msr_ram.sv -----
// ============================================================================
// msr_ram
// Simple dual-port synchronous RAM with one registered read port.
// ============================================================================
`default_nettype none

module msr_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msr_geom.sv -----
// ============================================================================
// msr_geom
// Derives the selected ring's corners, sides and length from the registers.
// ============================================================================
`default_nettype none

module msr_geom
    import msr_pkg::*;
(
    input  wire logic [DIM_W-1:0]   row_count,
    input  wire logic [DIM_W-1:0]   col_count,
    input  wire logic [SHELL_W-1:0] shell_number,
    output geom_t                   geom
);

    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] k;
    logic [DIM_W:0]   span;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [P_W-1:0]   ring_len;

    always_comb
    begin
        if (row_count == '0)
            n = DIM_W'(1);
        else if (row_count > DIM_W'(MAX_DIM))
            n = DIM_W'(MAX_DIM);
        else
            n = row_count;

        if (col_count == '0)
            m = DIM_W'(1);
        else if (col_count > DIM_W'(MAX_DIM))
            m = DIM_W'(MAX_DIM);
        else
            m = col_count;

        k        = DIM_W'(shell_number) - DIM_W'(1);
        span     = {k, 1'b1};
        h        = n - {k[DIM_W-2:0], 1'b0};
        w        = m - {k[DIM_W-2:0], 1'b0};
        ring_len = P_W'({h, 1'b0}) + P_W'({w, 1'b0}) - P_W'(4);

        geom.valid = (shell_number != '0) && (span <= {1'b0, n}) && (span <= {1'b0, m});
        geom.k     = k;
        geom.hr    = n - k - DIM_W'(1);
        geom.hc    = m - k - DIM_W'(1);
        geom.h     = h;
        geom.w     = w;
        geom.n     = n;
        geom.m     = m;

        // A ring one row high or one column wide holds each element once.
        if (h == DIM_W'(1))
            geom.cnt = CNT_W'(w);
        else if (w == DIM_W'(1))
            geom.cnt = CNT_W'(h);
        else
            geom.cnt = ring_len[CNT_W-1:0];
    end

endmodule

`default_nettype wire

// ----- rtl/msr_modu.sv -----
// ============================================================================
// msr_modu
// Bit-serial remainder unit: reduces the signed rotation by the ring length.
// ============================================================================
`default_nettype none

module msr_modu
    import msr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic signed [AMT_W-1:0] amount,
    input  wire logic [CNT_W-1:0]        cnt,
    output logic                         busy,
    output logic [CNT_W-1:0]             rm
);

    localparam int STEP_W = $clog2(AMT_W);

    typedef enum logic [1:0] {
        P_IDLE,
        P_LOAD,
        P_RUN,
        P_FIX
    } phase_t;

    phase_t             phase_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [AMT_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rm_reg;
    logic [CNT_W:0]     trial;
    logic [CNT_W-1:0]   rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, mag_reg[AMT_W-1]};
        if (trial >= {1'b0, cnt})
            rem_next = CNT_W'(trial - {1'b0, cnt});
        else
            rem_next = trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            rm_reg    <= '0;
            step_reg  <= '0;
        end
        else if (load)
        begin
            phase_reg <= P_LOAD;
        end
        else
        begin
            unique case (phase_reg)
                P_IDLE:
                begin
                    phase_reg <= P_IDLE;
                end
                P_LOAD:
                begin
                    neg_reg   <= amount[AMT_W-1];
                    mag_reg   <= amount[AMT_W-1] ? AMT_W'(-amount) : AMT_W'(amount);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    phase_reg <= P_RUN;
                end
                P_RUN:
                begin
                    rem_reg  <= rem_next;
                    mag_reg  <= {mag_reg[AMT_W-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(AMT_W - 1))
                        phase_reg <= P_FIX;
                end
                P_FIX:
                begin
                    // A negative remainder folds back into the ring length.
                    if (neg_reg && (rem_reg != '0))
                        rm_reg <= cnt - rem_reg;
                    else
                        rm_reg <= rem_reg;
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign busy = (phase_reg != P_IDLE);
    assign rm   = rm_reg;

endmodule

`default_nettype wire

// ----- rtl/matrix_shell_rotate.sv -----
// ============================================================================
// matrix_shell_rotate
// Matrix store with on-the-fly read-back of one rotated ring (shell).
// ============================================================================
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------
//  command  | start high while busy low  | cmd    (msr_in_t)
//  result   | done strobe, one cycle     | result (msr_out_t)
//  config   | cfg_we, no wait            | cfg_index, cfg_data
//
//  A write transaction stores its element at the accepting edge. A read
//  transaction steps through the position, address and data states: the ring
//  position is found, then mapped back to a source address, then the single
//  RAM read port is used, and done is high for one cycle in the data state.
//  The result cannot be held off by the receiver. A configuration write starts
//  the serial remainder unit, which keeps busy high while it reduces the
//  rotation by the ring length. After reset the block is ready at once; the
//  store holds nothing defined until elements are written.
//
`default_nettype none

module matrix_shell_rotate
    import msr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire msr_in_t              cmd,
    output logic                      done,
    output msr_out_t                  result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POS,
        S_ADDR,
        S_DATA
    } state_t;

    // Configuration registers.
    logic [DIM_W-1:0]          row_count_reg;
    logic [DIM_W-1:0]          col_count_reg;
    logic [SHELL_W-1:0]        shell_number_reg;
    logic signed [AMT_W-1:0]   rotate_amount_reg;

    // Read sequencer.
    state_t                    state_reg;
    state_t                    state_next;
    logic [IDX_W-1:0]          ri_reg;
    logic [IDX_W-1:0]          ci_reg;
    logic [P_W-1:0]            q_reg;
    logic [P_W-1:0]            q_next;
    logic                      on_reg;
    logic                      on_next;

    geom_t                     geom;
    logic                      div_busy;
    logic [CNT_W-1:0]          rm;

    logic                      accept;
    logic                      mem_we;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [DATA_W-1:0]         mem_rdata;

    // Ring geometry widened to the position width.
    logic [P_W-1:0]            pk;
    logic [P_W-1:0]            phr;
    logic [P_W-1:0]            phc;
    logic [P_W-1:0]            ph;
    logic [P_W-1:0]            pw;
    logic [P_W-1:0]            pcnt;
    logic [P_W-1:0]            pri;
    logic [P_W-1:0]            pci;
    logic [P_W-1:0]            p;
    logic [P_W-1:0]            qsum;
    logic [P_W-1:0]            sr;
    logic [P_W-1:0]            sc;
    logic                      in_box;
    logic                      on_side;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || div_busy;
    assign mem_we = accept && (cmd.opcode == OP_WRITE);
    assign mem_re = (state_reg == S_ADDR);

    assign pk   = P_W'(geom.k);
    assign phr  = P_W'(geom.hr);
    assign phc  = P_W'(geom.hc);
    assign ph   = P_W'(geom.h);
    assign pw   = P_W'(geom.w);
    assign pcnt = P_W'(geom.cnt);
    assign pri  = P_W'(ri_reg);
    assign pci  = P_W'(ci_reg);

    // Configuration writes land directly; the remainder unit restarts on each.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= DIM_W'(16);
            col_count_reg     <= DIM_W'(16);
            shell_number_reg  <= SHELL_W'(1);
            rotate_amount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[DIM_W-1:0];
                REG_COL_COUNT:     col_count_reg     <= cfg_data[DIM_W-1:0];
                REG_SHELL_NUMBER:  shell_number_reg  <= cfg_data[SHELL_W-1:0];
                REG_ROTATE_AMOUNT: rotate_amount_reg <= AMT_W'(cfg_data);
                default:           row_count_reg     <= row_count_reg;
            endcase
        end
    end

    msr_geom u_geom (
        .row_count    (row_count_reg),
        .col_count    (col_count_reg),
        .shell_number (shell_number_reg),
        .geom         (geom)
    );

    msr_modu u_modu (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (cfg_we),
        .amount (rotate_amount_reg),
        .cnt    (geom.cnt),
        .busy   (div_busy),
        .rm     (rm)
    );

    // Position stage: locate the element on the ring walk, which runs down the
    // left column, along the bottom, up the right column and back along the
    // top. The source position is then p minus the rotation, modulo the ring
    // length; both terms are already below the length, so one subtract folds it.
    always_comb
    begin
        in_box = (pri >= pk) && (pri <= phr) && (pci >= pk) && (pci <= phc)
                 && (pri < P_W'(geom.n)) && (pci < P_W'(geom.m));
        on_side = (pci == pk) || (pri == phr) || (pci == phc) || (pri == pk);

        if (pci == pk)
            p = pri - pk;
        else if (pri == phr)
            p = ph - P_W'(1) + (pci - pk);
        else if (pci == phc)
            p = ph + pw - P_W'(2) + (phr - pri);
        else
            p = {ph[P_W-2:0], 1'b0} + pw - P_W'(3) + (phc - pci);

        qsum = p + pcnt - P_W'(rm);
        if (qsum >= pcnt)
            q_next = qsum - pcnt;
        else
            q_next = qsum;

        on_next = geom.valid && in_box && on_side;
    end

    // Address stage: turn the source position back into a row and column.
    // Elements off the ring read their own location.
    always_comb
    begin
        if (q_reg < ph)
        begin
            sr = pk + q_reg;
            sc = pk;
        end
        else if (q_reg < ph + pw - P_W'(1))
        begin
            sr = phr;
            sc = pk + (q_reg - (ph - P_W'(1)));
        end
        else if (q_reg < {ph[P_W-2:0], 1'b0} + pw - P_W'(2))
        begin
            sr = phr - (q_reg - (ph + pw - P_W'(2)));
            sc = phc;
        end
        else
        begin
            sr = pk;
            sc = phc - (q_reg - ({ph[P_W-2:0], 1'b0} + pw - P_W'(3)));
        end

        if (on_reg)
            mem_raddr = {sr[IDX_W-1:0], sc[IDX_W-1:0]};
        else
            mem_raddr = {ri_reg, ci_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.opcode == OP_READ))
                    state_next = S_POS;
            end
            S_POS:  state_next = S_ADDR;
            S_ADDR: state_next = S_DATA;
            S_DATA: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            on_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ri_reg <= cmd.row_index;
                ci_reg <= cmd.col_index;
            end
            if (state_reg == S_POS)
            begin
                q_reg  <= q_next;
                on_reg <= on_next;
            end
        end
    end

    msr_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({cmd.row_index, cmd.col_index}),
        .wdata (cmd.element_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The RAM output register carries the element into the strobe cycle.
    assign done              = (state_reg == S_DATA);
    assign result.read_value = mem_rdata;
    assign result.on_ring    = on_reg;

endmodule

`default_nettype wire

// ----- rtl/msr_checker.sv -----
// ============================================================================
// msr_checker
// Port-level timing checks of the matrix shell rotation block.
// ============================================================================
`default_nettype none

`include "matrix_shell_rotate_defines.svh"

module msr_bind_checker
    import msr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire msr_in_t cmd,
    input wire logic    done,
    input wire logic    cfg_we
);

    `MSR_ASSERT_CLK(a_read_latency,
        start && !busy && (cmd.opcode == OP_READ) |-> ##3 done,
        "read transaction did not complete in four cycles")

    `MSR_ASSERT_CLK(a_write_silent,
        start && !busy && (cmd.opcode == OP_WRITE) && !cfg_we |=> !busy && !done,
        "write transaction produced a result or stalled")

    `MSR_ASSERT_CLK(a_cfg_busy, cfg_we |=> busy,
        "configuration write did not start the remainder unit")

    `MSR_ASSERT_NEVER(a_done_idle, done && !busy, "result strobe while idle")

endmodule

bind matrix_shell_rotate msr_bind_checker u_msr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .cfg_we (cfg_we)
);

`default_nettype wire

// ----- sim/msr_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// msr_checker
// Watches the command, result and register channels of the ring rotation
// block, predicts every read result and compares it with what comes back.
// ============================================================================

module msr_checker
    import msr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  msr_in_t              cmd,
    input  logic                 done,
    input  msr_out_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_checked,
    output int                   ring_results
);

    typedef struct {
        msr_out_t         value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pending_read_t;

    pending_read_t     pending_reads[$];
    pending_read_t     oldest_read;
    pending_read_t     incoming_read;
    logic [DATA_W-1:0] element_mem [MAX_DIM*MAX_DIM];

    // Shadow copy of the configuration registers.
    logic [4:0]        rows_reg;
    logic [4:0]        cols_reg;
    logic [3:0]        shell_reg;
    logic signed [15:0] turn_reg;

    function automatic int clamp_dim(input logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Element seen at (ri, ci) once the selected ring has been turned.
    function automatic msr_out_t rotated_element(input logic [IDX_W-1:0] ri,
                                                 input logic [IDX_W-1:0] ci);
        int       r, c, n, m, k, hr, hc, h, w, p, q, cnt, amt, sr, sc;
        msr_out_t res;
        r = int'(ri);
        c = int'(ci);
        res.read_value = element_mem[r*MAX_DIM + c];
        res.on_ring = 1'b0;
        n = clamp_dim(rows_reg);
        m = clamp_dim(cols_reg);
        k = int'(shell_reg) - 1;
        if (r >= n || c >= m || shell_reg == 0 || 2*k + 1 > n || 2*k + 1 > m)
            return res;
        hr = n - 1 - k;
        hc = m - 1 - k;
        h = hr - k + 1;
        w = hc - k + 1;
        if (r < k || r > hr || c < k || c > hc)
            return res;
        // Position along the ring, walking down, right, up, then left.
        if (c == k)
            p = r - k;
        else if (r == hr)
            p = h - 1 + (c - k);
        else if (c == hc)
            p = h + w - 2 + (hr - r);
        else if (r == k)
            p = 2*h + w - 3 + (hc - c);
        else
            return res;
        cnt = (h == 1) ? w : ((w == 1) ? h : 2*h + 2*w - 4);
        amt = int'(turn_reg) % cnt;
        if (amt < 0)
            amt += cnt;
        q = (p + cnt - amt) % cnt;
        if (q < h)
        begin
            sr = k + q;
            sc = k;
        end
        else if (q < h + w - 1)
        begin
            sr = hr;
            sc = k + q - (h - 1);
        end
        else if (q < 2*h + w - 2)
        begin
            sr = hr - (q - (h + w - 2));
            sc = hc;
        end
        else
        begin
            sr = k;
            sc = hc - (q - (2*h + w - 3));
        end
        res.read_value = element_mem[sr*MAX_DIM + sc];
        res.on_ring = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg        = 5'd16;
            cols_reg        = 5'd16;
            shell_reg       = 4'd1;
            turn_reg        = '0;
            pending_reads.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            ring_results    = 0;
        end
        else
        begin
            // The result leaving at this edge belongs to an earlier read.
            if (done)
            begin
                results_checked++;
                if (pending_reads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %h ring %0b arrived with no read waiting",
                                 $realtime, result.read_value, result.on_ring);
                end
                else
                begin
                    oldest_read = pending_reads.pop_front();
                    if (result.on_ring === 1'b1)
                        ring_results++;
                    if (result.read_value !== oldest_read.value.read_value ||
                        result.on_ring !== oldest_read.value.on_ring)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: read (%0d,%0d) expected %h ring %0b, got %h ring %0b",
                                     $realtime, oldest_read.row, oldest_read.col,
                                     oldest_read.value.read_value, oldest_read.value.on_ring,
                                     result.read_value, result.on_ring);
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd.opcode == OP_READ)
                begin
                    incoming_read = '{rotated_element(cmd.row_index, cmd.col_index),
                                      cmd.row_index, cmd.col_index};
                    pending_reads = {pending_reads, incoming_read};
                end
                else
                begin
                    element_mem[int'(cmd.row_index)*MAX_DIM + int'(cmd.col_index)] =
                        cmd.element_value;
                end
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROW_COUNT:     rows_reg = cfg_data[4:0];
                    REG_COL_COUNT:     cols_reg = cfg_data[4:0];
                    REG_SHELL_NUMBER:  shell_reg = cfg_data[3:0];
                    REG_ROTATE_AMOUNT: turn_reg = cfg_data;
                    default:           ;
                endcase
            end
            outstanding = pending_reads.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives the ring rotation block with element writes, rotated reads and
// register settings; a checker beside the block predicts every read result.
// ============================================================================
//
// The run begins by writing every element of the store, so that no later read
// (whether of the element itself or of the ring element rotated onto it) ever
// touches an entry that was never written. A short directed part follows: the
// value extremes, the rotation amount at its extremes, the single-row and
// single-column rings, the one-element centre ring, counts of zero and counts
// above the store size, shell zero and a shell past the centre. After that,
// a series of random register settings each carries a batch of random
// transactions. Most reads are aimed at the selected ring so the rotation
// arithmetic is exercised, and the rest land anywhere, in or out of the area
// in use. Writes keep changing the store between reads.
//
// Inputs change on the falling clock edge; the checker samples on the rising
// edge. Registers are only written while the block is idle: every expected
// result has come back and a few cycles have passed.

module tb_top;
    import msr_pkg::*;

    localparam int RANDOM_PHASES   = 24;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int SETTLE_CYCLES   = 6;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    msr_in_t              cmd       = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    msr_out_t             result;

    int mismatches;
    int outstanding;
    int results_checked;
    int ring_results;

    int sent_total    = 0;
    int sent_reads    = 0;
    int settings_used = 0;

    // The current register values, kept here to steer reads onto the ring.
    logic [4:0]  cur_rows  = 5'd16;
    logic [4:0]  cur_cols  = 5'd16;
    logic [3:0]  cur_shell = 4'd1;
    logic        zero_gaps = 1'b0;

    always #5 clk = ~clk;

    matrix_shell_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .done            (done),
        .result          (result),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .ring_results    (ring_results)
    );

    function automatic int clamp_dim(input logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the edge
    // that took the transaction. Start stays high when no gap follows, so a
    // back-to-back transaction never lowers and raises it in the same step.
    task automatic issue(input logic op, input int r, input int c, input logic [31:0] v);
        int gap;
        gap = zero_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd   <= '{op, 4'(r), 4'(c), v};
        start <= 1'b1;
        // Busy only moves on a rising edge, so it is stable here.
        while (busy)
            @(negedge clk);
        @(negedge clk);
        sent_total++;
        if (op == OP_READ)
            sent_reads++;
    endtask

    // Waits until the block has returned every read and is no longer busy.
    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        // A register write starts the remainder unit, which holds busy high.
        while (busy)
            @(negedge clk);
    endtask

    task automatic configure(input logic [4:0] rows, input logic [4:0] cols,
                             input logic [3:0] shell, input logic [15:0] turn);
        drain();
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COL_COUNT, CFG_W'(cols));
        write_reg(REG_SHELL_NUMBER, CFG_W'(shell));
        write_reg(REG_ROTATE_AMOUNT, turn);
        cur_rows  = rows;
        cur_cols  = cols;
        cur_shell = shell;
        settings_used++;
    endtask

    // Row or column count: mostly in range with small sizes favored, now and
    // then zero or above the store size.
    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
            1, 2:    return 5'd16;
            3, 4:    return 5'($urandom_range(1, 4));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic random_setting();
        logic [4:0]  rows;
        logic [4:0]  cols;
        logic [3:0]  shell;
        logic [15:0] turn;
        int          mn;
        rows = pick_count();
        cols = pick_count();
        mn = (clamp_dim(rows) < clamp_dim(cols)) ? clamp_dim(rows) : clamp_dim(cols);
        // Mostly a ring that exists, sometimes any shell from zero to 15.
        if ($urandom_range(0, 99) < 85)
            shell = 4'($urandom_range(1, (mn + 1) / 2));
        else
            shell = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       turn = 16'h8000;
            1:       turn = 16'h7FFF;
            2, 3, 4: turn = 16'(int'($urandom_range(0, 40)) - 20);
            default: turn = 16'($urandom());
        endcase
        configure(rows, cols, shell, turn);
    endtask

    task automatic random_item();
        int n, m, k, r, c;
        n = clamp_dim(cur_rows);
        m = clamp_dim(cur_cols);
        k = int'(cur_shell) - 1;
        if ($urandom_range(0, 99) < 35) begin
            issue(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
            return;
        end
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
        if (cur_shell != 0 && 2*k + 1 <= n && 2*k + 1 <= m && $urandom_range(0, 9) < 7) begin
            // Pick a side of the ring, then a spot along it.
            case ($urandom_range(0, 3))
                0: begin
                    r = $urandom_range(k, n - 1 - k);
                    c = k;
                end
                1: begin
                    r = n - 1 - k;
                    c = $urandom_range(k, m - 1 - k);
                end
                2: begin
                    r = $urandom_range(k, n - 1 - k);
                    c = m - 1 - k;
                end
                default: begin
                    r = k;
                    c = $urandom_range(k, m - 1 - k);
                end
            endcase
        end else if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, m - 1);
        end
        issue(OP_READ, r, c, $urandom());
    endtask

    task automatic directed_checks();
        // Value extremes at the four corners, two of them read back without rotation.
        issue(OP_WRITE, 0, 0, 32'h8000_0000);
        issue(OP_WRITE, 15, 15, 32'h7FFF_FFFF);
        issue(OP_WRITE, 0, 15, 32'hFFFF_FFFF);
        issue(OP_WRITE, 15, 0, 32'h0000_0000);
        issue(OP_READ, 0, 0, $urandom());
        issue(OP_READ, 15, 15, $urandom());
        issue(OP_READ, 7, 7, $urandom());
        // Rotation amount at both extremes on the outer ring.
        configure(5'd16, 5'd16, 4'd1, 16'h8000);
        issue(OP_READ, 0, 0, $urandom());
        issue(OP_READ, 15, 15, $urandom());
        configure(5'd16, 5'd16, 4'd1, 16'h7FFF);
        issue(OP_READ, 0, 15, $urandom());
        // Single-row matrix turned backward, plus a read below the rows in use.
        configure(5'd1, 5'd16, 4'd1, 16'hFFFF);
        issue(OP_READ, 0, 0, $urandom());
        issue(OP_READ, 9, 3, $urandom());
        // Single-column matrix, plus a read right of the columns in use.
        configure(5'd16, 5'd1, 4'd1, 16'd3);
        issue(OP_READ, 15, 0, $urandom());
        issue(OP_READ, 4, 9, $urandom());
        // A zero row count acts as one, an oversized column count as the store width.
        configure(5'd0, 5'd31, 4'd1, 16'd5);
        issue(OP_READ, 0, 7, $urandom());
        // Inner ring that is a single row.
        configure(5'd5, 5'd7, 4'd3, 16'hFFFE);
        issue(OP_READ, 2, 3, $urandom());
        // Shell past the centre leaves everything in place.
        configure(5'd4, 5'd4, 4'd3, 16'd1);
        issue(OP_READ, 1, 1, $urandom());
        // Shell zero selects no ring.
        configure(5'd8, 5'd8, 4'd0, 16'd2);
        issue(OP_READ, 0, 0, $urandom());
        // Innermost ring of the full store, and a one-element centre ring.
        configure(5'd16, 5'd16, 4'd8, 16'd1);
        issue(OP_READ, 8, 8, $urandom());
        configure(5'd3, 5'd3, 4'd2, 16'd9);
        issue(OP_READ, 1, 1, $urandom());
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole store before any read.
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++)
            issue(OP_WRITE, i / MAX_DIM, i % MAX_DIM, $urandom());

        directed_checks();

        // Every fourth setting runs its transactions back to back.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setting();
            zero_gaps = (ph % 4 == 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_item();
        end
        zero_gaps = 1'b0;

        drain();
        $display("Covered %0d transactions (%0d reads) across %0d register settings.",
                 sent_total, sent_reads, settings_used);
        $display("Checked %0d results, %0d of them taken from a rotated ring.",
                 results_checked, ring_results);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
